[rtl/core/particle_integrate_bounce_age_core_assert.svh]
// Assertion macros for the particle core. Each expects clk and arst_n in scope.
`ifndef PARTICLE_INTEGRATE_BOUNCE_AGE_CORE_ASSERT_SVH
`define PARTICLE_INTEGRATE_BOUNCE_AGE_CORE_ASSERT_SVH

// Same-cycle implication.
`define PIB_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pib assertion failed");

// Next-cycle implication.
`define PIB_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pib assertion failed");

`endif

[rtl/core/pib_pkg.sv]
`timescale 1ns / 1ps
package pib_pkg;

	localparam int FRAC_BITS = 16;
	localparam int unsigned G_FIX = ((98 << FRAC_BITS) + 5) / 10;
	localparam int unsigned DAMP_FIX = ((9 << FRAC_BITS) + 5) / 10;
	localparam int G_W = $clog2(G_FIX + 1);
	localparam int DAMP_W = $clog2(DAMP_FIX + 1);
	localparam int STR_W = 24;
	localparam int DT_W = 16;
	localparam int ACC_W = G_W + STR_W - FRAC_BITS;
	localparam int ACCP_W = G_W + STR_W;
	localparam int DVP_W = ACC_W + DT_W;
	localparam int AGE_W = 24;
	localparam logic [AGE_W-1:0] AGE_MAX = '1;
	localparam int WIDE_W = 52;

	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef enum logic [2:0] {
		CFG_GRAVITY_ENABLE   = 3'd0,
		CFG_GRAVITY_STRENGTH = 3'd1,
		CFG_FLOOR_HEIGHT     = 3'd2,
		CFG_BOUNCE_FACTOR    = 3'd3,
		CFG_LIFE_SPAN        = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic                is_live;
		logic signed [31:0]  pos_x;
		logic signed [31:0]  pos_y;
		logic signed [31:0]  pos_z;
		logic signed [31:0]  vel_x;
		logic signed [31:0]  vel_y;
		logic signed [31:0]  vel_z;
		logic [AGE_W-1:0]    age_in;
		logic signed [31:0]  spin_angle;
		logic [DT_W-1:0]     time_step;
	} in_item_t;

	typedef struct packed {
		logic                live_out;
		logic signed [31:0]  new_pos_x;
		logic signed [31:0]  new_pos_y;
		logic signed [31:0]  new_pos_z;
		logic signed [31:0]  new_vel_x;
		logic signed [31:0]  new_vel_y;
		logic signed [31:0]  new_vel_z;
		logic [AGE_W-1:0]    new_age;
		logic signed [31:0]  new_spin;
	} out_item_t;

	function automatic logic signed [31:0] sat32(input wide_t x);
		logic signed [31:0] r;
		if (x[WIDE_W-1:31] == '0 || x[WIDE_W-1:31] == '1) begin
			r = x[31:0];
		end else if (x[WIDE_W-1]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7fff_ffff;
		end
		return r;
	endfunction

endpackage

[rtl/core/particle_integrate_bounce_age_core.sv]
// Pipeline: 5 compute stages + output reg between request accept and result valid.
// Throughput: one request per cycle while out_ready keeps up; every stage holds under backpressure, bubbles collapse.
// Stages: gravity scale mult, dv/position mults, vy update + damp mults, vy*dt mult,
//   y add + bounce mult, floor compare/select into the output register.
// Reset (arst_n low, async): pipeline empties, registers return to gravity on,
//   strength 1.0, floor 0, bounce 0.5, life span 1.0.
`timescale 1ns / 1ps
`include "particle_integrate_bounce_age_core_assert.svh"
module particle_integrate_bounce_age_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pib_pkg::in_item_t     in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pib_pkg::out_item_t    out_data
);

	typedef struct packed {
		pib_pkg::in_item_t                  rec;
		logic [pib_pkg::ACC_W-1:0]          accel;
		logic [pib_pkg::ACC_W-1:0]          dv;
		logic signed [32:0]                 dpx;
		logic signed [32:0]                 dpz;
		logic signed [32:0]                 dpy;
		logic signed [31:0]                 vy;
		logic signed [31:0]                 px;
		logic signed [31:0]                 pz;
		logic signed [31:0]                 py;
		logic signed [31:0]                 dmx;
		logic signed [31:0]                 dmz;
		logic signed [31:0]                 bvy;
		logic [pib_pkg::AGE_W-1:0]          age;
	} work_t;

	// configuration
	logic                       grav_en_q;
	logic [23:0]                grav_str_q;
	logic signed [31:0]         floor_q;
	logic [16:0]                bounce_q;
	logic [23:0]                life_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_en_q  <= 1'b1;
			grav_str_q <= 24'd65536;
			floor_q    <= '0;
			bounce_q   <= 17'd32768;
			life_q     <= 24'd65536;
		end else if (cfg_we) begin
			unique case (pib_pkg::cfg_idx_t'(cfg_index))
				pib_pkg::CFG_GRAVITY_ENABLE:   grav_en_q  <= cfg_data[0];
				pib_pkg::CFG_GRAVITY_STRENGTH: grav_str_q <= cfg_data[23:0];
				pib_pkg::CFG_FLOOR_HEIGHT:     floor_q    <= cfg_data;
				pib_pkg::CFG_BOUNCE_FACTOR:    bounce_q   <= cfg_data[16:0];
				pib_pkg::CFG_LIFE_SPAN:        life_q     <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	work_t st_s1, st_s2, st_s3, st_s4, st_s5;
	work_t nx1, nx2, nx3, nx4, nx5;
	pib_pkg::out_item_t out_s6, nx6;

	assign rdy_s6 = !vld_s6 || out_ready;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign in_ready  = rdy_s1;
	assign out_valid = vld_s6;
	assign out_data  = out_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) st_s1  <= nx1;
		if (rdy_s2 && vld_s1)   st_s2  <= nx2;
		if (rdy_s3 && vld_s2)   st_s3  <= nx3;
		if (rdy_s4 && vld_s3)   st_s4  <= nx4;
		if (rdy_s5 && vld_s4)   st_s5  <= nx5;
		if (rdy_s6 && vld_s5)   out_s6 <= nx6;
	end

	// stage 1: gravity acceleration = G * strength
	always_comb begin : stg1
		logic [pib_pkg::ACCP_W-1:0] accp;
		accp = pib_pkg::ACCP_W'(pib_pkg::G_FIX) * pib_pkg::ACCP_W'(grav_str_q);
		nx1 = '0;
		nx1.rec = in_data;
		nx1.accel = accp[pib_pkg::FRAC_BITS +: pib_pkg::ACC_W];
	end

	// stage 2: dv = accel * dt, x/z displacement, age
	always_comb begin : stg2
		logic [pib_pkg::DVP_W-1:0] dvp;
		logic signed [48:0] pxp;
		logic signed [48:0] pzp;
		logic [pib_pkg::AGE_W:0] asum;
		nx2 = st_s1;
		dvp = pib_pkg::DVP_W'(st_s1.accel) * pib_pkg::DVP_W'(st_s1.rec.time_step);
		nx2.dv = dvp[pib_pkg::FRAC_BITS +: pib_pkg::ACC_W];
		pxp = 49'(st_s1.rec.vel_x) * 49'(signed'({1'b0, st_s1.rec.time_step}));
		pzp = 49'(st_s1.rec.vel_z) * 49'(signed'({1'b0, st_s1.rec.time_step}));
		nx2.dpx = 33'(pxp >>> pib_pkg::FRAC_BITS);
		nx2.dpz = 33'(pzp >>> pib_pkg::FRAC_BITS);
		asum = (pib_pkg::AGE_W + 1)'(st_s1.rec.age_in)
			+ (pib_pkg::AGE_W + 1)'(st_s1.rec.time_step);
		nx2.age = asum[pib_pkg::AGE_W] ? pib_pkg::AGE_MAX : asum[pib_pkg::AGE_W-1:0];
	end

	// stage 3: vy after gravity, x/z positions, damped vx/vz for a bounce
	always_comb begin : stg3
		pib_pkg::wide_t dvw;
		logic signed [48:0] dmxp;
		logic signed [48:0] dmzp;
		nx3 = st_s2;
		dvw = grav_en_q ? pib_pkg::wide_t'(signed'({1'b0, st_s2.dv})) : '0;
		nx3.vy = pib_pkg::sat32(pib_pkg::wide_t'(st_s2.rec.vel_y) - dvw);
		nx3.px = pib_pkg::sat32(pib_pkg::wide_t'(st_s2.rec.pos_x) + pib_pkg::wide_t'(st_s2.dpx));
		nx3.pz = pib_pkg::sat32(pib_pkg::wide_t'(st_s2.rec.pos_z) + pib_pkg::wide_t'(st_s2.dpz));
		dmxp = 49'(st_s2.rec.vel_x)
			* 49'(signed'({1'b0, pib_pkg::DAMP_W'(pib_pkg::DAMP_FIX)}));
		dmzp = 49'(st_s2.rec.vel_z)
			* 49'(signed'({1'b0, pib_pkg::DAMP_W'(pib_pkg::DAMP_FIX)}));
		nx3.dmx = pib_pkg::sat32(pib_pkg::wide_t'(dmxp >>> pib_pkg::FRAC_BITS));
		nx3.dmz = pib_pkg::sat32(pib_pkg::wide_t'(dmzp >>> pib_pkg::FRAC_BITS));
	end

	// stage 4: y displacement uses the updated vy
	always_comb begin : stg4
		logic signed [48:0] pyp;
		nx4 = st_s3;
		pyp = 49'(st_s3.vy) * 49'(signed'({1'b0, st_s3.rec.time_step}));
		nx4.dpy = 33'(pyp >>> pib_pkg::FRAC_BITS);
	end

	// stage 5: y position, reflected vy (only used when vy < 0)
	always_comb begin : stg5
		logic signed [32:0] negv;
		logic signed [50:0] bp;
		nx5 = st_s4;
		nx5.py = pib_pkg::sat32(pib_pkg::wide_t'(st_s4.rec.pos_y) + pib_pkg::wide_t'(st_s4.dpy));
		negv = -(33'(st_s4.vy));
		bp = 51'(negv) * 51'(signed'({1'b0, bounce_q}));
		nx5.bvy = pib_pkg::sat32(pib_pkg::wide_t'(bp >>> pib_pkg::FRAC_BITS));
	end

	// stage 6: floor test, life test, inactive records pass through
	always_comb begin : stg6
		logic bounce;
		bounce = (st_s5.py < floor_q) && st_s5.vy[31];
		nx6.live_out  = st_s5.rec.is_live;
		nx6.new_pos_x = st_s5.rec.pos_x;
		nx6.new_pos_y = st_s5.rec.pos_y;
		nx6.new_pos_z = st_s5.rec.pos_z;
		nx6.new_vel_x = st_s5.rec.vel_x;
		nx6.new_vel_y = st_s5.rec.vel_y;
		nx6.new_vel_z = st_s5.rec.vel_z;
		nx6.new_age   = st_s5.rec.age_in;
		nx6.new_spin  = st_s5.rec.spin_angle;
		if (st_s5.rec.is_live) begin
			nx6.live_out  = !(st_s5.age >= life_q);
			nx6.new_pos_x = st_s5.px;
			nx6.new_pos_y = bounce ? floor_q : st_s5.py;
			nx6.new_pos_z = st_s5.pz;
			nx6.new_vel_x = bounce ? st_s5.dmx : st_s5.rec.vel_x;
			nx6.new_vel_y = bounce ? st_s5.bvy : st_s5.vy;
			nx6.new_vel_z = bounce ? st_s5.dmz : st_s5.rec.vel_z;
			nx6.new_age   = st_s5.age;
			// spin rate is 1.0, so the angle just gains dt (wraps)
			nx6.new_spin  = st_s5.rec.spin_angle + 32'(st_s5.rec.time_step);
		end
	end

	`PIB_ASSERT_NXT(a_in_to_s1, in_valid && in_ready, vld_s1)
	`PIB_ASSERT_NXT(a_s3_hold, vld_s3 && !rdy_s4, vld_s3 && $stable(st_s3))
	`PIB_ASSERT_IMP(a_live_age, out_valid && out_data.live_out, out_data.new_age != pib_pkg::AGE_MAX)

endmodule
